@@ design/hste_pkg.sv @@
// ----------------------------------------------------------------------------
// hste_pkg
// Shared types and constants for the halfword store table engine: table
// geometry, action codes, sequencer states and inter-module structs.
// ----------------------------------------------------------------------------
package hste_pkg;

    localparam int STORE_DEPTH = 512;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int DATA_W      = 16;
    localparam int IDX_W       = 16;
    localparam int FIDX_W      = 9;
    localparam int IN_W        = 72;
    localparam int OUT_W       = 32;

    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [DATA_W-1:0] HEADER_WORD = 16'hA5A5;
    localparam logic [DATA_W-1:0] ZERO_WORD   = 16'h0000;

    typedef enum logic [2:0] {
        ACT_READ  = 3'd0,
        ACT_WRITE = 3'd1,
        ACT_FIND  = 3'd2,
        ACT_FILL  = 3'd3,
        ACT_SWAP  = 3'd4,
        ACT_CLEAR = 3'd5
    } t_action;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_FIND,
        ST_FILL,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_SWAP_C,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic [2:0]       action;
        logic [IDX_W-1:0] index;
        logic [IDX_W-1:0] second_index;
        logic [IDX_W-1:0] count;
        logic [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              found;
        logic [FIDX_W-1:0] found_index;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

@@ design/hste_ram.sv @@
// ----------------------------------------------------------------------------
// hste_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module hste_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/hste_seq.sv @@
// ----------------------------------------------------------------------------
// hste_seq
// Action sequencer: runs the table init sweep after reset, then decodes each
// word, drives the RAM ports step by step and hands back one result.
// ----------------------------------------------------------------------------
module hste_seq
    import hste_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_item             i_item,
    output t_ram_req          o_ram,
    input  logic [DATA_W-1:0] i_rdata,
    input  logic              i_out_free,
    output t_push             o_push
);

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [ADDR_W-1:0] r_last, n_last;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [ADDR_W-1:0] r_idx2, n_idx2;
    logic [ADDR_W-1:0] r_pend_addr, n_pend_addr;
    logic [DATA_W-1:0] r_val, n_val;
    logic [DATA_W-1:0] r_tmp, n_tmp;
    logic              r_rd_ok, n_rd_ok;
    t_result           r_res, n_res;

    logic              idx_ok;
    logic              idx2_ok;
    logic [IDX_W:0]    fill_end;
    logic [31:0]       pend_wide;

    assign idx_ok    = 32'(i_item.index) < 32'(STORE_DEPTH);
    assign idx2_ok   = 32'(i_item.second_index) < 32'(STORE_DEPTH);
    assign fill_end  = (IDX_W + 1)'(i_item.index) + (IDX_W + 1)'(i_item.count);
    assign pend_wide = 32'(r_pend_addr);
    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last      <= n_last;
        r_idx       <= n_idx;
        r_idx2      <= n_idx2;
        r_pend_addr <= n_pend_addr;
        r_val       <= n_val;
        r_tmp       <= n_tmp;
        r_rd_ok     <= n_rd_ok;
        r_res       <= n_res;
    end

    always_comb begin
        logic    fin;
        t_result res;

        n_state     = r_state;
        n_ptr       = r_ptr;
        n_last      = r_last;
        n_idx       = r_idx;
        n_idx2      = r_idx2;
        n_pend_addr = r_pend_addr;
        n_val       = r_val;
        n_tmp       = r_tmp;
        n_rd_ok     = r_rd_ok;
        n_res       = r_res;
        o_ram       = '0;
        o_push      = '0;
        fin         = 1'b0;
        res         = '0;

        unique case (r_state)
            ST_INIT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_ptr;
                o_ram.wdata = (r_ptr == '0) ? HEADER_WORD : ZERO_WORD;
                n_ptr       = r_ptr + ADDR_W'(1);
                if (r_ptr == LAST_ADDR) begin
                    n_ptr   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_idx  = i_item.index[ADDR_W-1:0];
                    n_idx2 = i_item.second_index[ADDR_W-1:0];
                    n_val  = i_item.value;
                    unique case (t_action'(i_item.action))
                        ACT_READ: begin
                            o_ram.raddr = i_item.index[ADDR_W-1:0];
                            n_rd_ok     = idx_ok;
                            n_state     = ST_READ;
                        end
                        ACT_WRITE: begin
                            o_ram.we    = idx_ok;
                            o_ram.waddr = i_item.index[ADDR_W-1:0];
                            o_ram.wdata = i_item.value;
                            fin         = 1'b1;
                        end
                        ACT_FIND: begin
                            o_ram.raddr = ADDR_W'(1);
                            n_pend_addr = ADDR_W'(1);
                            n_ptr       = ADDR_W'(2);
                            n_state     = ST_FIND;
                        end
                        ACT_FILL: begin
                            if (idx_ok && i_item.count != '0) begin
                                n_ptr   = i_item.index[ADDR_W-1:0];
                                n_last  = (fill_end > (IDX_W + 1)'(STORE_DEPTH)) ?
                                          LAST_ADDR : ADDR_W'(fill_end - (IDX_W + 1)'(1));
                                n_state = ST_FILL;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        ACT_SWAP: begin
                            if (idx_ok && idx2_ok) begin
                                o_ram.raddr = i_item.index[ADDR_W-1:0];
                                n_state     = ST_SWAP_A;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        ACT_CLEAR: begin
                            n_ptr   = ADDR_W'(1);
                            n_last  = LAST_ADDR;
                            n_val   = ZERO_WORD;
                            n_state = ST_FILL;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                res.read_value = r_rd_ok ? i_rdata : ZERO_WORD;
                fin            = 1'b1;
            end
            ST_FIND: begin
                o_ram.raddr = r_ptr;
                n_ptr       = r_ptr + ADDR_W'(1);
                n_pend_addr = r_ptr;
                if (i_rdata == r_val) begin
                    res.found       = 1'b1;
                    res.found_index = pend_wide[FIDX_W-1:0];
                    fin             = 1'b1;
                end else if (r_pend_addr == LAST_ADDR) begin
                    fin = 1'b1;
                end
            end
            ST_FILL: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_ptr;
                o_ram.wdata = r_val;
                n_ptr       = r_ptr + ADDR_W'(1);
                if (r_ptr == r_last) begin
                    fin = 1'b1;
                end
            end
            ST_SWAP_A: begin
                n_tmp       = i_rdata;
                o_ram.raddr = r_idx2;
                n_state     = ST_SWAP_B;
            end
            ST_SWAP_B: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx;
                o_ram.wdata = i_rdata;
                n_state     = ST_SWAP_C;
            end
            ST_SWAP_C: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx2;
                o_ram.wdata = r_tmp;
                fin         = 1'b1;
            end
            ST_HOLD: begin
                if (i_out_free) begin
                    o_push.valid = 1'b1;
                    o_push.res   = r_res;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (fin) begin
            if (i_out_free) begin
                o_push.valid = 1'b1;
                o_push.res   = res;
                n_state      = ST_IDLE;
            end else begin
                n_res   = res;
                n_state = ST_HOLD;
            end
        end
    end

endmodule

@@ design/halfword_store_table_engine_core.sv @@
// ----------------------------------------------------------------------------
// halfword_store_table_engine_core
// Table of 16-bit words with read, write, find, fill, swap and clear actions,
// one result word per input word.
//
//   channel | dir | payload (low bit up)
//   --------+-----+------------------------------------------------------------
//   s_axis  | in  | action[2:0] index[18:3] second_index[34:19] count[50:35]
//           |     | value[66:51], zero pad [71:67]
//   m_axis  | out | read_value[15:0] found[16] found_index[25:17], pad [31:26]
//
// Read waits for the registered RAM read; swap reads both words, then writes
// them crosswise; fill writes count words (clipped at the depth); clear writes
// all but the header word; find reads up from address 1 to a match or the end.
// Single read and write ports set this pace. After reset an init sweep writes
// the whole table; no word is accepted until it ends. A full output register
// while a result is ready holds the engine until the result is taken.
// ----------------------------------------------------------------------------
module halfword_store_table_engine_core
    import hste_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // action, index, second_index, count, value
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // read_value, found, found_index
);

    t_item             item;
    t_ram_req          ram_req;
    t_push             push;
    logic [DATA_W-1:0] rdata;
    logic              out_free;

    logic              r_m_valid;
    t_result           r_m_res;

    assign item.action       = s_axis_tdata[2:0];
    assign item.index        = s_axis_tdata[18:3];
    assign item.second_index = s_axis_tdata[34:19];
    assign item.count        = s_axis_tdata[50:35];
    assign item.value        = s_axis_tdata[66:51];

    assign out_free = !r_m_valid || m_axis_tready;

    hste_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_item     (item),
        .o_ram      (ram_req),
        .i_rdata    (rdata),
        .i_out_free (out_free),
        .o_push     (push)
    );

    hste_ram #(
        .DEPTH (STORE_DEPTH),
        .AW    (ADDR_W),
        .DW    (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (push.valid) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push.valid) begin
            r_m_res <= push.res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_m_res.found_index, r_m_res.found, r_m_res.read_value};

endmodule

@@ sim/hste_table_checker.sv @@
// ----------------------------------------------------------------------------
// hste_table_checker
// Watches both stream channels of the halfword store table engine. Every word
// accepted on the input updates a private copy of the table and queues the
// reply it should produce. Every word accepted on the output is compared
// field by field with the oldest queued reply. Mismatches and replies that
// arrive with nothing queued are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module hste_table_checker
    import hste_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // action, index, second_index, count, value
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [OUT_W-1:0] i_m_tdata,   // read_value, found, found_index
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    logic [DATA_W-1:0] shadow_words [STORE_DEPTH];
    t_result           predicted_results [$];

    function automatic t_result apply_action(logic [IN_W-1:0] word);
        t_item             it;
        t_result           reply;
        logic [DATA_W-1:0] tmp;
        it.action       = word[2:0];
        it.index        = word[18:3];
        it.second_index = word[34:19];
        it.count        = word[50:35];
        it.value        = word[66:51];
        reply = '0;
        case (it.action)
            ACT_READ: begin
                if (it.index < STORE_DEPTH) reply.read_value = shadow_words[it.index];
            end
            ACT_WRITE: begin
                if (it.index < STORE_DEPTH) shadow_words[it.index] = it.value;
            end
            ACT_FIND: begin
                for (int k = 1; k < STORE_DEPTH; k++) begin
                    if (!reply.found && shadow_words[k] == it.value) begin
                        reply.found       = 1'b1;
                        reply.found_index = FIDX_W'(k);
                    end
                end
            end
            ACT_FILL: begin
                for (int p = int'(it.index);
                     p < int'(it.index) + int'(it.count) && p < STORE_DEPTH; p++) begin
                    shadow_words[p] = it.value;
                end
            end
            ACT_SWAP: begin
                if (it.index < STORE_DEPTH && it.second_index < STORE_DEPTH) begin
                    tmp                           = shadow_words[it.index];
                    shadow_words[it.index]        = shadow_words[it.second_index];
                    shadow_words[it.second_index] = tmp;
                end
            end
            ACT_CLEAR: begin
                for (int k = 1; k < STORE_DEPTH; k++) shadow_words[k] = ZERO_WORD;
            end
            default: ;
        endcase
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < STORE_DEPTH; k++) shadow_words[k] = ZERO_WORD;
            shadow_words[0] = HEADER_WORD;
            predicted_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.read_value  = i_m_tdata[15:0];
                got.found       = i_m_tdata[16];
                got.found_index = i_m_tdata[25:17];
                if (predicted_results.size() == 0) begin
                    if (o_fail_count < REPORT_LIMIT)
                        $display("%0t: unexpected reply read_value=%h found=%b found_index=%0d",
                                 $realtime, got.read_value, got.found, got.found_index);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = predicted_results.pop_front();
                    if (got.read_value !== want.read_value || got.found !== want.found ||
                        got.found_index !== want.found_index) begin
                        if (o_fail_count < REPORT_LIMIT)
                            $display({"%0t: reply mismatch read_value exp %h got %h, ",
                                      "found exp %b got %b, found_index exp %0d got %0d"},
                                     $realtime, want.read_value, got.read_value,
                                     want.found, got.found, want.found_index,
                                     got.found_index);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                predicted_results.push_back(apply_action(i_s_tdata));
        end
        o_pending <= predicted_results.size();
    end

endmodule

@@ sim/halfword_store_table_engine_core_tb.sv @@
// ----------------------------------------------------------------------------
// halfword_store_table_engine_core_tb
// Drives action words into the table engine: a directed pass over range edges,
// header handling, clipping and unused codes, then random words biased toward
// valid indices and values already stored. Both sides idle at random; one
// phase stalls the output for a long stretch, one drains before resuming and
// one runs without gaps. The checker instance predicts and compares replies.
// ----------------------------------------------------------------------------
module halfword_store_table_engine_core_tb
    import hste_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    localparam int RANDOM_ITEMS   = 630;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4 * STORE_DEPTH + 4 * LONG_HOLD + 200;

    logic             i_clk;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;   // action, index, second_index, count, value
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;         // read_value, found, found_index

    int                table_fail_count;
    int                replies_due;
    bit                hold_request = 1'b0;
    bit                burst_mode   = 1'b0;
    logic [DATA_W-1:0] stored_values [$];

    halfword_store_table_engine_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hste_table_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (table_fail_count),
        .o_pending    (replies_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int stall_len;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                m_axis_tready <= 1'b1;
                hold_request = 1'b0;
            end else if (!burst_mode && $urandom_range(0, 99) < 30) begin
                stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                        : $urandom_range(1, 3);
                m_axis_tready <= 1'b0;
                repeat (stall_len) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [IDX_W-1:0] random_index();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)       return IDX_W'($urandom_range(0, STORE_DEPTH - 1));
        else if (pick == 6) return IDX_W'($urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 3));
        else if (pick == 7) return IDX_W'($urandom_range(0, 8));
        else if (pick == 8) return IDX_W'($urandom_range(0, 65535));
        else                return IDX_W'(65535 - $urandom_range(0, 3));
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)      it.action = ACT_READ;
        else if (pick < 53) it.action = ACT_WRITE;
        else if (pick < 68) it.action = ACT_FIND;
        else if (pick < 80) it.action = ACT_FILL;
        else if (pick < 92) it.action = ACT_SWAP;
        else if (pick < 95) it.action = ACT_CLEAR;
        else if (pick < 98) it.action = ACT_SPARE_6;
        else                it.action = ACT_SPARE_7;
        it.index        = random_index();
        it.second_index = random_index();
        pick = $urandom_range(0, 99);
        if (pick < 70)      it.count = IDX_W'($urandom_range(0, 16));
        else if (pick < 90) it.count = IDX_W'($urandom_range(17, STORE_DEPTH + 8));
        else if (pick < 95) it.count = IDX_W'($urandom_range(0, 65535));
        else                it.count = '0;
        pick = $urandom_range(0, 99);
        if (pick < 15)      it.value = ZERO_WORD;
        else if (pick < 20) it.value = HEADER_WORD;
        else if (pick < 25) it.value = 16'hFFFF;
        else                it.value = DATA_W'($urandom_range(0, 65535));
        if (it.action == ACT_FIND && stored_values.size() > 0 && $urandom_range(0, 3) != 0)
            it.value = stored_values[$urandom_range(0, stored_values.size() - 1)];
        return it;
    endfunction

    task automatic issue(input t_item it, input bit end_idle);
        logic [IN_W-1:0] word;
        int              gap_len;
        word        = '0;
        word[2:0]   = it.action;
        word[18:3]  = it.index;
        word[34:19] = it.second_index;
        word[50:35] = it.count;
        word[66:51] = it.value;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        if (it.action == ACT_WRITE || it.action == ACT_FILL) begin
            stored_values.push_back(it.value);
            if (stored_values.size() > 32) void'(stored_values.pop_front());
        end
        if (burst_mode) begin
            gap_len = 0;
        end else begin
            gap_len = $urandom_range(0, 99);
            if (gap_len < 55)      gap_len = 0;
            else if (gap_len < 92) gap_len = $urandom_range(1, 3);
            else                   gap_len = $urandom_range(10, 60);
        end
        if (end_idle && gap_len == 0) gap_len = 1;
        if (gap_len > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap_len - 1) @(negedge i_clk);
        end
    endtask

    initial begin
        bit phase_edge;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue(t_item'{ACT_READ,  16'd0, 16'd0, 16'd0, 16'd0}, 1'b0);
        issue(t_item'{ACT_READ,  16'(STORE_DEPTH - 1), 16'd0, 16'd0, 16'd0}, 1'b0);
        issue(t_item'{ACT_READ,  16'(STORE_DEPTH), 16'd0, 16'd0, 16'd0}, 1'b0);
        issue(t_item'{ACT_READ,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
        issue(t_item'{ACT_WRITE, 16'd1, 16'd0, 16'd0, 16'hFFFF}, 1'b0);
        issue(t_item'{ACT_WRITE, 16'(STORE_DEPTH - 1), 16'd0, 16'd0, 16'h1234}, 1'b0);
        issue(t_item'{ACT_WRITE, 16'(STORE_DEPTH), 16'd0, 16'd0, 16'h5A5A}, 1'b0);
        issue(t_item'{ACT_WRITE, 16'hFFFF, 16'd0, 16'd0, 16'h5A5A}, 1'b0);
        issue(t_item'{ACT_READ,  16'd1, 16'd0, 16'd0, 16'd0}, 1'b0);
        issue(t_item'{ACT_READ,  16'(STORE_DEPTH - 1), 16'd0, 16'd0, 16'd0}, 1'b0);
        issue(t_item'{ACT_FIND,  16'd0, 16'd0, 16'd0, 16'hFFFF}, 1'b0);
        issue(t_item'{ACT_FIND,  16'd0, 16'd0, 16'd0, 16'h0000}, 1'b0);
        issue(t_item'{ACT_FIND,  16'd0, 16'd0, 16'd0, HEADER_WORD}, 1'b0);
        issue(t_item'{ACT_FIND,  16'd0, 16'd0, 16'd0, 16'h5A5A}, 1'b0);
        issue(t_item'{ACT_FILL,  16'(STORE_DEPTH - 5), 16'd0, 16'd20, 16'h7E7E}, 1'b0);
        issue(t_item'{ACT_FILL,  16'd3, 16'd0, 16'd0, 16'h1111}, 1'b0);
        issue(t_item'{ACT_FILL,  16'(STORE_DEPTH), 16'd0, 16'd4, 16'h2222}, 1'b0);
        issue(t_item'{ACT_FILL,  16'd0, 16'd0, 16'd3, 16'hBEEF}, 1'b0);
        issue(t_item'{ACT_SWAP,  16'd1, 16'(STORE_DEPTH - 1), 16'd0, 16'd0}, 1'b0);
        issue(t_item'{ACT_SWAP,  16'd5, 16'd5, 16'd0, 16'd0}, 1'b0);
        issue(t_item'{ACT_SWAP,  16'd1, 16'(STORE_DEPTH), 16'd0, 16'd0}, 1'b0);
        issue(t_item'{ACT_SWAP,  16'hFFFF, 16'd0, 16'd0, 16'd0}, 1'b0);
        issue(t_item'{ACT_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0);
        issue(t_item'{ACT_READ,  16'd0, 16'd0, 16'd0, 16'd0}, 1'b0);
        issue(t_item'{ACT_SPARE_6, 16'd1, 16'd2, 16'd3, 16'hFFFF}, 1'b0);
        issue(t_item'{ACT_SPARE_7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            phase_edge = (n == 199 || n == 399 || n == 449 || n == 519 ||
                          n == RANDOM_ITEMS - 1);
            issue(random_item(), phase_edge);
            if (phase_edge) begin
                @(posedge i_clk);
                case (n)
                    199: hold_request = 1'b1;
                    399: while (replies_due != 0) @(posedge i_clk);
                    449: burst_mode = 1'b1;
                    519: burst_mode = 1'b0;
                    default: ;
                endcase
            end
        end

        while (replies_due != 0) @(posedge i_clk);
        repeat (STORE_DEPTH + 16) @(posedge i_clk);
        if (table_fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
